### rtl/core/asgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgd_pkg
// Shared constants and types for the ADPCM sound group decoder.
// ----------------------------------------------------------------------------
package asgd_pkg;

  localparam int unsigned GroupBytes  = 128;
  localparam int unsigned GroupAw     = 7;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned UnitSamples = 28;
  localparam int unsigned PredW       = 19;

  // Request commands
  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdDecode = 1'b1;

  // Configuration register indexes
  localparam logic RegLevelA = 1'b0;
  localparam logic RegStereo = 1'b1;

  // Filter coefficients, scaled by 256
  localparam logic signed [10:0] CoefK0 [4] = '{11'sd0, 11'sd240, 11'sd460, 11'sd392};
  localparam logic signed [10:0] CoefK1 [4] = '{11'sd0, 11'sd0, -11'sd208, -11'sd220};

  // Predictor control from the sequencer
  typedef struct packed {
    logic       en;
    logic [1:0] filt;
  } pred_ctl_t;

endpackage

### rtl/core/asgd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgd_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module asgd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/asgd_pred.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgd_pred
// Second-order predictor: registered products, then sum and divide by 256
// rounding toward zero.
// ----------------------------------------------------------------------------
module asgd_pred (
  input  logic                                 clk_i,
  input  asgd_pkg::pred_ctl_t                  ctl_i,
  input  logic signed [asgd_pkg::SampleW-1:0]  p1_i,
  input  logic signed [asgd_pkg::SampleW-1:0]  p2_i,
  output logic signed [asgd_pkg::PredW-1:0]    pred_o
);

  logic signed [26:0] prod0_q, prod0_d;
  logic signed [26:0] prod1_q, prod1_d;
  logic signed [26:0] sum;
  logic signed [26:0] biased;

  assign prod0_d = p1_i * asgd_pkg::CoefK0[ctl_i.filt];
  assign prod1_d = p2_i * asgd_pkg::CoefK1[ctl_i.filt];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      prod0_q <= prod0_d;
      prod1_q <= prod1_d;
    end
  end

  // bias negative sums so the arithmetic shift truncates toward zero
  assign sum    = prod0_q + prod1_q;
  assign biased = sum + {19'd0, {8{sum[26]}}};
  assign pred_o = biased[26:8];

endmodule

### rtl/core/adpcm_sound_group_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_sound_group_decoder
// Loads a 128-byte sound group and decodes it unit by unit into PCM samples.
// ----------------------------------------------------------------------------
// A load request (cmd 0) writes one group byte into the group RAM. A decode
// request (cmd 1) on a full group reads the unit header, then runs 28
// samples through the RAM read / predictor multiply / sum and saturate
// loop; the loop waits while a result held in the output register is not
// taken. The sample recursion through the channel history bounds the loop.
// Requests are taken only while no unit is being decoded; a result may
// still wait in the output register when the next request is accepted.
module adpcm_sound_group_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] sample_o,
  output logic        to_right_o,
  output logic        unit_last_o,
  output logic        group_last_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StHdr  = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;
  localparam logic [1:0] StSum  = 2'd3;

  localparam logic [4:0] LastSample = 5'(asgd_pkg::UnitSamples - 1);

  logic [1:0] state_q, state_d;
  logic       level_a_q, stereo_q;
  logic [7:0] bytes_loaded_q, bytes_loaded_d;
  logic [2:0] next_unit_q, next_unit_d;
  logic [4:0] sample_cnt_q, sample_cnt_d;
  logic [3:0] shift_q, shift_d;
  logic [1:0] filt_q, filt_d;
  logic signed [7:0]  data_q, data_d;
  logic signed [15:0] left_p1_q, left_p2_q, right_p1_q, right_p2_q;
  logic signed [15:0] sample_q;
  logic       out_valid_q, to_right_q, unit_last_q, group_last_q;

  logic       in_acc, out_acc;
  logic       do_load, do_start, do_drop;
  logic       group_full, unit_ok, last_unit, is_right;
  logic       emit, advance, last_sample;
  logic       ram_re;
  logic [6:0] ram_raddr, hdr_addr, data_addr;
  logic [4:0] rd_sample;
  logic [1:0] data_off;
  logic [7:0] ram_rdata;
  logic [3:0] expo, rng;
  logic signed [15:0] p1, p2;
  logic signed [18:0] pred;
  logic signed [22:0] scaled, total;
  logic signed [15:0] sat_val;
  asgd_pkg::pred_ctl_t pred_ctl;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_q && out_ready_i;

  assign group_full = bytes_loaded_q[7];
  assign unit_ok    = !(level_a_q && next_unit_q[2]);
  assign last_unit  = level_a_q ? (next_unit_q == 3'd3) : (next_unit_q == 3'd7);
  assign is_right   = stereo_q && next_unit_q[0];

  assign do_load  = in_acc && (cmd_i == asgd_pkg::CmdLoad) && !group_full;
  assign do_start = in_acc && (cmd_i == asgd_pkg::CmdDecode) && group_full && unit_ok;
  assign do_drop  = in_acc && (cmd_i == asgd_pkg::CmdDecode) && group_full && !unit_ok;

  assign last_sample = (sample_cnt_q == LastSample);
  assign emit        = (state_q == StSum) && (!out_valid_q || out_ready_i);
  assign advance     = emit && !last_sample;

  // group RAM addressing
  assign hdr_addr  = level_a_q ? {4'd0, next_unit_q} : 7'd4 + {4'd0, next_unit_q};
  assign rd_sample = (state_q == StSum) ? sample_cnt_q + 5'd1 : sample_cnt_q;
  assign data_off  = level_a_q ? next_unit_q[1:0] : next_unit_q[2:1];
  assign data_addr = 7'd16 + {rd_sample, 2'b00} + {5'd0, data_off};
  assign ram_raddr = (state_q == StIdle) ? hdr_addr : data_addr;
  assign ram_re    = do_start || (state_q == StHdr) || advance;

  asgd_ram #(
    .Width(asgd_pkg::ByteW),
    .Depth(asgd_pkg::GroupBytes)
  ) u_group_ram (
    .clk_i  (clk_i),
    .we_i   (do_load),
    .waddr_i(bytes_loaded_q[asgd_pkg::GroupAw-1:0]),
    .wdata_i(data_byte_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign p1 = is_right ? right_p1_q : left_p1_q;
  assign p2 = is_right ? right_p2_q : left_p2_q;

  assign pred_ctl.en   = (state_q == StMul);
  assign pred_ctl.filt = filt_q;

  asgd_pred u_pred (
    .clk_i (clk_i),
    .ctl_i (pred_ctl),
    .p1_i  (p1),
    .p2_i  (p2),
    .pred_o(pred)
  );

  // header decode: clamp range to the exponent, gain is 2 << (expo - range)
  assign expo    = level_a_q ? 4'd8 : 4'd12;
  assign rng     = (ram_rdata[3:0] > expo) ? expo : ram_rdata[3:0];
  assign shift_d = (state_q == StHdr) ? expo - rng + 4'd1 : shift_q;
  assign filt_d  = (state_q == StHdr) ? ram_rdata[5:4] : filt_q;

  always_comb begin
    data_d = data_q;
    if (state_q == StMul) begin
      if (level_a_q) begin
        data_d = ram_rdata;
      end else if (next_unit_q[0]) begin
        data_d = {{4{ram_rdata[7]}}, ram_rdata[7:4]};
      end else begin
        data_d = {{4{ram_rdata[3]}}, ram_rdata[3:0]};
      end
    end
  end

  assign scaled = {{15{data_q[7]}}, data_q} <<< shift_q;
  assign total  = scaled + {{4{pred[18]}}, pred};

  always_comb begin
    if (total > 23'sd32767) begin
      sat_val = 16'sh7fff;
    end else if (total < -23'sd32768) begin
      sat_val = -16'sh8000;
    end else begin
      sat_val = total[15:0];
    end
  end

  always_comb begin
    state_d        = state_q;
    bytes_loaded_d = bytes_loaded_q;
    next_unit_d    = next_unit_q;
    sample_cnt_d   = sample_cnt_q;
    unique case (state_q)
      StIdle: begin
        if (do_load) begin
          bytes_loaded_d = bytes_loaded_q + 8'd1;
        end
        if (do_drop) begin
          bytes_loaded_d = 8'd0;
          next_unit_d    = 3'd0;
        end
        if (do_start) begin
          sample_cnt_d = 5'd0;
          state_d      = StHdr;
        end
      end
      StHdr: state_d = StMul;
      StMul: state_d = StSum;
      StSum: begin
        if (emit) begin
          if (last_sample) begin
            state_d = StIdle;
            if (last_unit) begin
              next_unit_d    = 3'd0;
              bytes_loaded_d = 8'd0;
            end else begin
              next_unit_d = next_unit_q + 3'd1;
            end
          end else begin
            sample_cnt_d = sample_cnt_q + 5'd1;
            state_d      = StMul;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      level_a_q      <= 1'b0;
      stereo_q       <= 1'b0;
      bytes_loaded_q <= 8'd0;
      next_unit_q    <= 3'd0;
      sample_cnt_q   <= 5'd0;
      left_p1_q      <= '0;
      left_p2_q      <= '0;
      right_p1_q     <= '0;
      right_p2_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      bytes_loaded_q <= bytes_loaded_d;
      next_unit_q    <= next_unit_d;
      sample_cnt_q   <= sample_cnt_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == asgd_pkg::RegLevelA) begin
          level_a_q <= cfg_data_i;
        end
        if (cfg_idx_i == asgd_pkg::RegStereo) begin
          stereo_q <= cfg_data_i;
        end
      end
      // shift the channel history on every produced sample
      if (emit) begin
        if (is_right) begin
          right_p2_q <= right_p1_q;
          right_p1_q <= sat_val;
        end else begin
          left_p2_q <= left_p1_q;
          left_p1_q <= sat_val;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    filt_q  <= filt_d;
    data_q  <= data_d;
    if (emit) begin
      sample_q     <= sat_val;
      to_right_q   <= is_right;
      unit_last_q  <= last_sample;
      group_last_q <= last_sample && last_unit;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_o     = sample_q;
  assign to_right_o   = to_right_q;
  assign unit_last_o  = unit_last_q;
  assign group_last_o = group_last_q;

`ifndef NO_ASSERTIONS
  a_group_last_in_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && group_last_o |-> unit_last_o)
    else $error("group_last without unit_last");

  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_loaded_q <= 8'd128)
    else $error("byte count above group size");

  a_decode_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> group_full && unit_ok)
    else $error("decode running on a partial group or bad unit");

  a_sample_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_cnt_q <= LastSample)
    else $error("sample index past end of unit");
`endif

endmodule
